/* rtl/core/mppf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppf_pkg
// Shared widths, reset values and the result type of the peak finder.
// ----------------------------------------------------------------------------
package mppf_pkg;

	localparam int MaxSamples = 4096;
	localparam int SampleW    = 16;
	localparam int TimeW      = 32;
	localparam int IdxW       = $clog2(MaxSamples);
	localparam int ThrW       = 15;

	localparam logic [ThrW-1:0] ThrReset = ThrW'(1000);

	// Input tdata: sample, then sample_time; padded to whole bytes
	localparam int InDataW  = ((SampleW + TimeW + 7) / 8) * 8;
	// Output tdata: peak_value, peak_time, peak_index; padded to whole bytes
	localparam int OutBits  = SampleW + TimeW + IdxW;
	localparam int OutDataW = ((OutBits + 7) / 8) * 8;

	typedef struct packed {
		logic               no_signal;
		logic [IdxW-1:0]    peak_index;
		logic [TimeW-1:0]   peak_time;
		logic signed [SampleW-1:0] peak_value;
	} result_t;

endpackage

/* rtl/core/mppf_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppf_track
// Input register and pulse tracking: opens, follows and closes pulses on
// the registered sample and forms at most one result per item.
// ----------------------------------------------------------------------------
module mppf_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mppf_pkg::ThrW-1:0]     threshold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [mppf_pkg::SampleW-1:0] in_sample,
	input  logic [mppf_pkg::TimeW-1:0]    in_time,
	input  logic                          in_last,
	input  logic                          advance,
	output logic                          res_valid,
	output mppf_pkg::result_t             res
);

	logic                                valid_s1;
	logic signed [mppf_pkg::SampleW-1:0] sample_s1;
	logic [mppf_pkg::TimeW-1:0]          time_s1;
	logic                                last_s1;

	logic                                in_pulse_q;
	logic                                seen_pulse_q;
	logic signed [mppf_pkg::SampleW-1:0] held_max_q;
	logic [mppf_pkg::IdxW-1:0]           held_index_q;
	logic [mppf_pkg::TimeW-1:0]          held_time_q;
	logic [mppf_pkg::IdxW-1:0]           sample_count_q;

	logic                                fire;
	logic signed [mppf_pkg::SampleW+2:0] thr_x;
	logic signed [mppf_pkg::SampleW+2:0] v_x;
	logic signed [mppf_pkg::SampleW+2:0] diff2;
	logic                                above_max;
	logic                                do_open;
	logic                                do_grow;
	logic                                do_close;
	logic                                seen_nx;

	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	// Hold the accepted item until the result side can take its outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_sample;
			time_s1   <= in_time;
			last_s1   <= in_last;
		end
	end

	// Compare the sample against the threshold, the end band and the held maximum
	always_comb begin
		thr_x     = (mppf_pkg::SampleW+3)'(signed'({1'b0, threshold}));
		v_x       = (mppf_pkg::SampleW+3)'(sample_s1);
		diff2     = (thr_x - v_x) <<< 1;
		above_max = sample_s1 > held_max_q;
		do_open   = !in_pulse_q && (v_x >= thr_x) && above_max;
		do_grow   = in_pulse_q && above_max;
		do_close  = in_pulse_q && !above_max && (v_x < thr_x) && (diff2 <= thr_x);
		seen_nx   = seen_pulse_q || do_open;
	end

	// Form the result: a closed pulse, or no-signal at a pulseless waveform end
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (fire && do_close) begin
			res.peak_value = held_max_q;
			res.peak_time  = held_time_q;
			res.peak_index = held_index_q;
			res_valid      = 1'b1;
		end else if (fire && last_s1 && !seen_nx) begin
			res.no_signal  = 1'b1;
			res_valid      = 1'b1;
		end
	end

	// Advance tracking state; clear it after the last item of a waveform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q     <= 1'b0;
			seen_pulse_q   <= 1'b0;
			held_max_q     <= '0;
			held_index_q   <= '0;
			held_time_q    <= '0;
			sample_count_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				in_pulse_q     <= 1'b0;
				seen_pulse_q   <= 1'b0;
				held_max_q     <= '0;
				held_index_q   <= '0;
				held_time_q    <= '0;
				sample_count_q <= '0;
			end else begin
				sample_count_q <= sample_count_q + 1'b1;
				seen_pulse_q   <= seen_nx;
				if (do_open || do_grow || do_close) begin
					held_max_q   <= sample_s1;
					held_index_q <= sample_count_q;
					held_time_q  <= time_s1;
				end
				if (do_open) begin
					in_pulse_q <= 1'b1;
				end else if (do_close) begin
					in_pulse_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/core/mppf_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppf_out
// Result register: holds a finished result until the sink takes it and
// lets the tracking stage advance whenever the register is free.
// ----------------------------------------------------------------------------
module mppf_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  mppf_pkg::result_t res,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output mppf_pkg::result_t out_res
);

	logic              valid_s2;
	mppf_pkg::result_t res_s2;

	assign advance   = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	// Load a new result or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

/* rtl/core/multi_pulse_peak_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pulse_peak_finder
// Threshold pulse peak detector over a stream of waveform samples.
// ----------------------------------------------------------------------------
// The block takes one sample item every clock cycle unless m_tready stalls it
// and gives its results through an input register and a result register
// with the pulse decision between them. A pulse opens on a sample at or above
// the threshold and above the held maximum, and closes on a sample in the band
// [threshold/2, threshold); each close gives one peak result. A waveform
// (ended by tlast) with no pulse gives one result with no_signal set and the
// other fields zero; a pulse still open at waveform end is dropped. Write the
// threshold only while the block is idle.
// ----------------------------------------------------------------------------
module multi_pulse_peak_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mppf_pkg::ThrW-1:0]         cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mppf_pkg::InDataW-1:0]      s_tdata,   // sample, sample_time
	input  logic                              s_tlast,   // last_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mppf_pkg::OutDataW-1:0]     m_tdata,   // peak_value, peak_time, peak_index
	output logic                              m_tuser    // no_signal
);

	logic [mppf_pkg::ThrW-1:0] threshold_q;
	logic                      advance;
	logic                      res_valid;
	mppf_pkg::result_t         res;
	mppf_pkg::result_t         out_res;

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mppf_pkg::ThrReset;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	mppf_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[mppf_pkg::SampleW-1:0]),
		.in_time   (s_tdata[mppf_pkg::SampleW +: mppf_pkg::TimeW]),
		.in_last   (s_tlast),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	mppf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result fields, lowest first
	assign m_tdata = mppf_pkg::OutDataW'({out_res.peak_index, out_res.peak_time,
		out_res.peak_value});
	assign m_tuser = out_res.no_signal;

endmodule
